// ===== hw/rtl/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg: shared constants and types for the seeded byte string hash
// mixing constants, multiplier request type
// ----------------------------------------------------------------------------
package sbh_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;

    localparam logic [WORD_W-1:0] DEFAULT_SEED = 64'h7f4a7c1506fe123d;
    localparam logic [WORD_W-1:0] GOLDEN       = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] SM_MUL1      = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] SM_MUL2      = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] BODY_ADD     = 64'h9ddfea08eb382d69;
    localparam logic [WORD_W-1:0] FMIX_MUL1    = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] FMIX_MUL2    = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned       ROT_AMOUNT   = 17;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

endpackage

// ===== hw/rtl/sbh_mul.sv =====
// ----------------------------------------------------------------------------
// sbh_mul: iterative 64x64 multiplier, low 64 bits of the product
// one 32x32 multiplier over the LL, LH and HL partial products, done pulses once the product holds
// ----------------------------------------------------------------------------
module sbh_mul
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbh_pkg::mul_req_t             req,
    output logic                          done,
    output logic [sbh_pkg::WORD_W-1:0]    prod
);

    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_LH = 2'd1;
    localparam logic [1:0] PP_HL = 2'd2;

    logic [sbh_pkg::WORD_W-1:0] a_reg;
    logic [sbh_pkg::WORD_W-1:0] b_reg;
    logic [sbh_pkg::WORD_W-1:0] acc_reg;
    logic [sbh_pkg::WORD_W-1:0] acc_next;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [sbh_pkg::HALF_W-1:0] op_a;
    logic [sbh_pkg::HALF_W-1:0] op_b;
    logic [sbh_pkg::WORD_W-1:0] pp;

    always_comb
    begin
        op_a = (cnt_reg == PP_HL) ? a_reg[sbh_pkg::WORD_W-1:sbh_pkg::HALF_W]
                                  : a_reg[sbh_pkg::HALF_W-1:0];
        op_b = (cnt_reg == PP_LH) ? b_reg[sbh_pkg::WORD_W-1:sbh_pkg::HALF_W]
                                  : b_reg[sbh_pkg::HALF_W-1:0];
        pp   = {{sbh_pkg::HALF_W{1'b0}}, op_a} * {{sbh_pkg::HALF_W{1'b0}}, op_b};
    end

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = PP_LL;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // cross terms only reach the upper half
            if (cnt_reg == PP_LL)
                acc_next = pp;
            else
                acc_next = {acc_reg[sbh_pkg::WORD_W-1:sbh_pkg::HALF_W]
                            + pp[sbh_pkg::HALF_W-1:0],
                            acc_reg[sbh_pkg::HALF_W-1:0]};
            if (cnt_reg == PP_HL)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= PP_LL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hw/rtl/seeded_byte_string_hash64.sv =====
// ----------------------------------------------------------------------------
// seeded_byte_string_hash64: seeded 64-bit hash of a word-packed byte string
// splitmix64 word mixing and fmix64 finalizer on one shared multiplier
// ----------------------------------------------------------------------------
// body word: two 64-bit multiplies, then ready for the next word
// last word, 0-7 bytes: four 64-bit multiplies, hash valid in the same cycle that ready returns
// last word, 8 bytes: a body pass first, then the finalizing pass on an empty tail
// each 64-bit multiply runs as partial products on the single 32x32 multiplier
// the finished hash waits in an output register while the next words arrive
// reset: asynchronous active low, seed back to default, no string open
module seeded_byte_string_hash64
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbh_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sbh_pkg::WORD_W-1:0]    word,
    input  logic [3:0]                    byte_count,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sbh_pkg::WORD_W-1:0]    hash
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ADV  = 7'b0000010,
        ST_SM1  = 7'b0000100,
        ST_SM2  = 7'b0001000,
        ST_FM1  = 7'b0010000,
        ST_FM2  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [sbh_pkg::WORD_W-1:0] seed_reg;
    logic [sbh_pkg::WORD_W-1:0] mix_reg;
    logic [sbh_pkg::WORD_W-1:0] mix_next;
    logic [sbh_pkg::WORD_W-1:0] acc_reg;
    logic [sbh_pkg::WORD_W-1:0] acc_next;
    logic [sbh_pkg::WORD_W-1:0] hash_reg;
    logic [sbh_pkg::WORD_W-1:0] hash_next;
    logic                       in_string_reg;
    logic                       in_string_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       fin_reg;
    logic                       fin_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    sbh_pkg::mul_req_t          mreq;
    logic                       mdone;
    logic [sbh_pkg::WORD_W-1:0] p;

    logic                       short_last;
    logic [sbh_pkg::WORD_W-1:0] tail_mask;
    logic [sbh_pkg::WORD_W-1:0] eff_seed;
    logic [sbh_pkg::WORD_W-1:0] mix_start;
    logic [sbh_pkg::WORD_W-1:0] adv_sum;
    logic [sbh_pkg::WORD_W-1:0] sm_in;
    logic [sbh_pkg::WORD_W-1:0] sm_mid;
    logic [sbh_pkg::WORD_W-1:0] z;
    logic [sbh_pkg::WORD_W-1:0] z_rot;
    logic [sbh_pkg::WORD_W-1:0] acc_body;
    logic [sbh_pkg::WORD_W-1:0] fm_pre;
    logic [sbh_pkg::WORD_W-1:0] fm_in;
    logic [sbh_pkg::WORD_W-1:0] fm_mid;
    logic [sbh_pkg::WORD_W-1:0] hash_fin;

    sbh_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .done  (mdone),
        .prod  (p)
    );

    // datapath around the multiplier
    always_comb
    begin
        // counts of 8 and above mean a full word
        short_last = last & ~byte_count[3];
        for (int i = 0; i < 8; i++)
            tail_mask[8*i +: 8] = (4'(i) < byte_count) ? 8'hff : 8'h00;

        eff_seed  = (seed_reg == '0) ? sbh_pkg::DEFAULT_SEED : seed_reg;
        mix_start = in_string_reg ? mix_reg : eff_seed;

        adv_sum  = mix_reg + sbh_pkg::GOLDEN;
        sm_in    = adv_sum ^ (adv_sum >> 30);
        sm_mid   = p ^ (p >> 27);
        z        = p ^ (p >> 31);
        z_rot    = (z << sbh_pkg::ROT_AMOUNT)
                   | (z >> (sbh_pkg::WORD_W - sbh_pkg::ROT_AMOUNT));
        acc_body = (acc_reg ^ z_rot) + sbh_pkg::BODY_ADD;
        fm_pre   = acc_reg ^ z;
        fm_in    = fm_pre ^ (fm_pre >> 33);
        fm_mid   = p ^ (p >> 33);
        hash_fin = (fm_mid == '0) ? sbh_pkg::GOLDEN : fm_mid;
    end

    always_comb
    begin
        state_next     = state_reg;
        mix_next       = mix_reg;
        acc_next       = acc_reg;
        hash_next      = hash_reg;
        in_string_next = in_string_reg;
        last_next      = last_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        mreq.start     = 1'b0;
        mreq.a         = '0;
        mreq.b         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mix_next       = mix_start ^ (short_last ? (word & tail_mask) : word);
                    acc_next       = in_string_reg ? acc_reg : '0;
                    in_string_next = 1'b1;
                    last_next      = last;
                    fin_next       = short_last;
                    state_next     = ST_ADV;
                end
            end
            ST_ADV:
            begin
                mix_next   = adv_sum;
                mreq.start = 1'b1;
                mreq.a     = sm_in;
                mreq.b     = sbh_pkg::SM_MUL1;
                state_next = ST_SM1;
            end
            ST_SM1:
            begin
                if (mdone)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = sm_mid;
                    mreq.b     = sbh_pkg::SM_MUL2;
                    state_next = ST_SM2;
                end
            end
            ST_SM2:
            begin
                if (mdone)
                begin
                    if (fin_reg)
                    begin
                        mreq.start = 1'b1;
                        mreq.a     = fm_in;
                        mreq.b     = sbh_pkg::FMIX_MUL1;
                        state_next = ST_FM1;
                    end
                    else
                    begin
                        acc_next = acc_body;
                        // full last word: second pass with an empty tail
                        if (last_reg)
                        begin
                            fin_next   = 1'b1;
                            state_next = ST_ADV;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_FM1:
            begin
                if (mdone)
                begin
                    mreq.start = 1'b1;
                    mreq.a     = fm_mid;
                    mreq.b     = sbh_pkg::FMIX_MUL2;
                    state_next = ST_FM2;
                end
            end
            ST_FM2:
            begin
                if (mdone)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // product stays in the multiplier until the next start
                if (!out_valid_reg || out_ready)
                begin
                    hash_next      = hash_fin;
                    out_valid_next = 1'b1;
                    in_string_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= sbh_pkg::DEFAULT_SEED;
            in_string_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_string_reg <= in_string_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                seed_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg  <= mix_next;
        acc_reg  <= acc_next;
        hash_reg <= hash_next;
        last_reg <= last_next;
        fin_reg  <= fin_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign hash      = hash_reg;

endmodule
